@@ sv/tia_pkg.sv @@
`timescale 1ns / 1ps

package tia_pkg;

  localparam int SAMPLE_W = 14;
  localparam int LEVEL_W  = 4;
  localparam int PERIOD_W = 7;

  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_CTRL = 2'd1,
    KIND_FREQ = 2'd2,
    KIND_VOL  = 2'd3
  } kind_t;

  localparam logic [1:0] STEREO_RAW   = 2'd0;
  localparam logic [1:0] STEREO_BLEND = 2'd1;
  localparam logic [1:0] STEREO_MONO  = 2'd2;

  localparam logic [3:0] MODE_HOLD_A   = 4'd0;
  localparam logic [3:0] MODE_P15      = 4'd1;
  localparam logic [3:0] MODE_P15_DIV  = 4'd2;
  localparam logic [3:0] MODE_P15_POLY = 4'd3;
  localparam logic [3:0] MODE_DIV_A    = 4'd6;
  localparam logic [3:0] MODE_POLY_A   = 4'd7;
  localparam logic [3:0] MODE_NOISE    = 4'd8;
  localparam logic [3:0] MODE_POLY_B   = 4'd9;
  localparam logic [3:0] MODE_DIV_B    = 4'd10;
  localparam logic [3:0] MODE_HOLD_B   = 4'd11;
  localparam logic [3:0] DIV3_MODE     = 4'd12;
  localparam logic [3:0] MODE_DIV_C    = 4'd14;
  localparam logic [3:0] MODE_POLY_C   = 4'd15;

  localparam logic [14:0] P15_RESET    = 15'h143b;
  localparam logic [30:0] P31DIV_RESET = 31'h7ffc0000;
  localparam logic [30:0] P31POL_RESET = 31'h167c6ea1;
  localparam logic [31:0] NOISE_RESET  = 32'h00001000;
  localparam logic [31:0] NOISE_TAPS   = 32'h0000002d;

  typedef struct packed {
    logic       tick;
    logic       wr_ctrl;
    logic       wr_freq;
    logic       wr_vol;
    logic [7:0] value;
  } chan_cmd_t;

  // floor(p / 3) for 7-bit p via reciprocal multiply
  function automatic logic [PERIOD_W-1:0] div3(input logic [PERIOD_W-1:0] p);
    logic [15:0] prod;
    prod = 16'(p) * 16'd171;
    return prod[15:9];
  endfunction

endpackage

@@ sv/tia_two_channel_audio_generator.sv @@
`timescale 1ns / 1ps
// a tick passes the input stage, then its sample pair is registered in the result stage
// one item per cycle unless stalled; a register write leaves the input stage next cycle
// a tick stalls in the input stage only while an unread sample pair is held
// reset (rst, synchronous): patterns to their seed values, other channel state
// to zero, stereo_mode to blend, both pipeline stages empty

module tia_two_channel_audio_generator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    kind,
  input  logic                          channel,
  input  logic [7:0]                    value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tia_pkg::SAMPLE_W-1:0]  left_sample,
  output logic [tia_pkg::SAMPLE_W-1:0]  right_sample,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_data
);
  import tia_pkg::*;

  logic               s1_valid;
  kind_t              s1_kind;
  logic               s1_channel;
  logic [7:0]         s1_value;
  logic               s1_tick;
  logic               out_free;
  logic               s1_advance;
  logic               tick_fire;
  logic [1:0]         stereo_mode;
  chan_cmd_t          cmd [2];
  logic [LEVEL_W-1:0] lvl [2];
  logic [SAMPLE_W-1:0] mix_left, mix_right;

  assign s1_tick    = s1_valid && (s1_kind == KIND_TICK);
  assign out_free   = !out_valid || out_ready;
  assign s1_advance = s1_valid && (!s1_tick || out_free);
  assign tick_fire  = s1_tick && out_free;
  assign in_ready   = !s1_valid || s1_advance;
  assign cfg_ready  = 1'b1;

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind    <= kind_t'(kind);
      s1_channel <= channel;
      s1_value   <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stereo_mode <= STEREO_BLEND;
    end else if (cfg_valid && cfg_ready) begin
      stereo_mode <= cfg_data;
    end
  end

  for (genvar i = 0; i < 2; i++) begin : g_chan
    always_comb begin
      cmd[i].tick    = tick_fire;
      cmd[i].wr_ctrl = s1_valid && (s1_kind == KIND_CTRL) && (s1_channel == 1'(i));
      cmd[i].wr_freq = s1_valid && (s1_kind == KIND_FREQ) && (s1_channel == 1'(i));
      cmd[i].wr_vol  = s1_valid && (s1_kind == KIND_VOL) && (s1_channel == 1'(i));
      cmd[i].value   = s1_value;
    end

    tia_chan u_chan (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd[i]),
      .tick_level (lvl[i])
    );
  end

  tia_mix u_mix (
    .lvl_left    (lvl[0]),
    .lvl_right   (lvl[1]),
    .stereo_mode (stereo_mode),
    .mix_left    (mix_left),
    .mix_right   (mix_right)
  );

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tick_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_fire) begin
      left_sample  <= mix_left;
      right_sample <= mix_right;
    end
  end

`ifndef NO_ASSERTIONS
  a_stall_only_on_full: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_advance) |-> (out_valid && !out_ready))
    else $error("input stage stalled without a held result");

  a_tick_gives_result: assert property (@(posedge clk) disable iff (rst)
    tick_fire |=> out_valid)
    else $error("tick transfer did not produce a result");

  a_sample_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (left_sample <= 14'd9600 && right_sample <= 14'd9600))
    else $error("sample out of range");
`endif

endmodule

@@ sv/tia_chan.sv @@
`timescale 1ns / 1ps

module tia_chan (
  input  logic                         clk,
  input  logic                         rst,
  input  tia_pkg::chan_cmd_t           cmd,
  output logic [tia_pkg::LEVEL_W-1:0]  tick_level
);
  import tia_pkg::*;

  logic [3:0]          mode, mode_next;
  logic [PERIOD_W-1:0] period, period_next;
  logic [LEVEL_W-1:0]  level, level_next;
  logic [PERIOD_W-1:0] countdown, countdown_next;
  logic [LEVEL_W-1:0]  cur_level, cur_level_next;
  logic [14:0]         p15, p15_next;
  logic [30:0]         p31div, p31div_next;
  logic [30:0]         p31pol, p31pol_next;
  logic [31:0]         noise, noise_next;

  always_comb begin
    logic [PERIOD_W-1:0] fp;
    logic                hit;
    mode_next      = mode;
    period_next    = period;
    level_next     = level;
    countdown_next = countdown;
    cur_level_next = cur_level;
    p15_next       = p15;
    p31div_next    = p31div;
    p31pol_next    = p31pol;
    noise_next     = noise;
    fp             = PERIOD_W'({2'b00, cmd.value[4:0]} + 7'd1);
    hit            = 1'b0;

    if (cmd.wr_ctrl) begin
      if (cmd.value[3:0] >= DIV3_MODE) begin
        if (mode < DIV3_MODE) begin
          period_next = PERIOD_W'(9'(period) * 9'd3);
        end
      end else if (mode >= DIV3_MODE) begin
        period_next = div3(period);
      end
      mode_next = cmd.value[3:0];
    end

    if (cmd.wr_freq) begin
      if (mode >= DIV3_MODE) begin
        period_next = PERIOD_W'(9'(fp) * 9'd3);
      end else begin
        period_next = fp;
      end
    end

    if (cmd.wr_vol) begin
      level_next = cmd.value[3:0];
    end

    if (cmd.tick) begin
      if (mode == MODE_HOLD_A || mode == MODE_HOLD_B) begin
        cur_level_next = level;
      end else if (countdown > PERIOD_W'(1)) begin
        countdown_next = countdown - PERIOD_W'(1);
      end else begin
        countdown_next = period;
        case (mode)
          MODE_P15: begin
            hit      = p15[0];
            p15_next = {p15[0], p15[14:1]};
          end
          MODE_P15_DIV: begin
            hit         = p15[0] & p31div[0];
            p15_next    = {p15[0], p15[14:1]};
            p31div_next = {p31div[0], p31div[30:1]};
          end
          MODE_P15_POLY: begin
            hit         = p15[0] & p31pol[0];
            p15_next    = {p15[0], p15[14:1]};
            p31pol_next = {p31pol[0], p31pol[30:1]};
          end
          MODE_DIV_A, MODE_DIV_B, MODE_DIV_C: begin
            hit         = p31div[0];
            p31div_next = {p31div[0], p31div[30:1]};
          end
          MODE_POLY_A, MODE_POLY_B, MODE_POLY_C: begin
            hit         = p31pol[0];
            p31pol_next = {p31pol[0], p31pol[30:1]};
          end
          MODE_NOISE: begin
            hit        = noise[31];
            noise_next = {noise[30:0], 1'b0} ^ (noise[31] ? NOISE_TAPS : 32'd0);
          end
          default: begin
            hit = (cur_level == '0);
          end
        endcase
        cur_level_next = hit ? level : '0;
      end
    end
  end

  assign tick_level = cur_level_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_HOLD_A;
      period    <= '0;
      level     <= '0;
      countdown <= '0;
      cur_level <= '0;
      p15       <= P15_RESET;
      p31div    <= P31DIV_RESET;
      p31pol    <= P31POL_RESET;
      noise     <= NOISE_RESET;
    end else begin
      mode      <= mode_next;
      period    <= period_next;
      level     <= level_next;
      countdown <= countdown_next;
      cur_level <= cur_level_next;
      p15       <= p15_next;
      p31div    <= p31div_next;
      p31pol    <= p31pol_next;
      noise     <= noise_next;
    end
  end

endmodule

@@ sv/tia_mix.sv @@
`timescale 1ns / 1ps

module tia_mix (
  input  logic [tia_pkg::LEVEL_W-1:0]  lvl_left,
  input  logic [tia_pkg::LEVEL_W-1:0]  lvl_right,
  input  logic [1:0]                   stereo_mode,
  output logic [tia_pkg::SAMPLE_W-1:0] mix_left,
  output logic [tia_pkg::SAMPLE_W-1:0] mix_right
);
  import tia_pkg::*;

  logic [SAMPLE_W-1:0] a, b, sum;

  assign a   = SAMPLE_W'(lvl_left);
  assign b   = SAMPLE_W'(lvl_right);
  assign sum = a + b;

  always_comb begin
    case (stereo_mode)
      STEREO_RAW: begin
        mix_left  = a << 9;
        mix_right = b << 9;
      end
      STEREO_MONO: begin
        mix_left  = SAMPLE_W'(sum * SAMPLE_W'(320));
        mix_right = SAMPLE_W'(sum * SAMPLE_W'(320));
      end
      default: begin
        mix_left  = SAMPLE_W'(a * SAMPLE_W'(384) + b * SAMPLE_W'(256));
        mix_right = SAMPLE_W'(a * SAMPLE_W'(256) + b * SAMPLE_W'(384));
      end
    endcase
  end

endmodule
